/* hdl/sprite_xor_framebuffer_defines.svh */
// Assertion macros shared by the framebuffer RTL.
// Each macro checks on the rising edge of clk and is off while arst_n is low.
`ifndef SPRITE_XOR_FRAMEBUFFER_DEFINES_SVH
`define SPRITE_XOR_FRAMEBUFFER_DEFINES_SVH

`ifndef SYNTH

// Checks a property that holds in the same cycle.
`define SXF_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sprite_xor_framebuffer: check failed");

// Checks that a condition in one cycle leads to another in the next cycle.
`define SXF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sprite_xor_framebuffer: check failed");

`else

`define SXF_ASSERT(label, prop)
`define SXF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/sxf_pkg.sv */
`default_nettype none

package sxf_pkg;

	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 32;

	// Column and row address widths.
	localparam int XW = $clog2(SCREEN_WIDTH);
	localparam int YW = $clog2(SCREEN_HEIGHT);
	// A draw row is the wrapped origin row plus a row index of up to 15.
	localparam int YSUM_W = $clog2(SCREEN_HEIGHT + 15);
	// A screen row with room for a sprite byte past the right edge.
	localparam int MASK_W = SCREEN_WIDTH + 8;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2
	} opcode_t;

	typedef logic [XW-1:0] x_wrap_t [256];
	typedef logic [YW-1:0] y_wrap_t [256];

	function automatic x_wrap_t build_x_wrap();
		x_wrap_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = XW'(i % SCREEN_WIDTH);
		end
		return t;
	endfunction

	function automatic y_wrap_t build_y_wrap();
		y_wrap_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = YW'(i % SCREEN_HEIGHT);
		end
		return t;
	endfunction

	// Origin coordinate modulo the screen size, as constant lookup tables.
	localparam x_wrap_t X_WRAP = build_x_wrap();
	localparam y_wrap_t Y_WRAP = build_y_wrap();

endpackage

`default_nettype wire

/* hdl/sprite_xor_framebuffer.sv */
// Each input transfer passes through the input register, then the result register, before its result is valid.
// Throughput: one item per cycle unless stalled, for all ops; a draw touches one screen row.
// The rate is set by the single framebuffer row read per cycle; a draw rewrites only that row.
// Reset (arst_n low) clears every pixel, the collision flag and both valid flags at once.
// Output stall back-pressures the input stage only when the result register is occupied.
`default_nettype none
`include "sprite_xor_framebuffer_defines.svh"

module sprite_xor_framebuffer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] origin_x,
	input  wire logic [7:0] origin_y,
	input  wire logic [3:0] row_index,
	input  wire logic [7:0] sprite_row,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic       collision,
	output      logic [7:0] read_pixels,
	output      logic       display_updated
);

	// The screen is held in flip-flops, one register per row, column c in bit c.
	logic [sxf_pkg::SCREEN_WIDTH-1:0] rows_q [sxf_pkg::SCREEN_HEIGHT];
	logic                              collision_seen_q;

	// Input register. The origin is wrapped on the way in so that the
	// compute stage sees only in-range coordinates.
	logic                        s1_valid_q;
	logic [1:0]                  opcode_s1;
	logic [sxf_pkg::XW-1:0]      x0_s1;
	logic [sxf_pkg::YW-1:0]      y0_s1;
	logic [3:0]                  row_index_s1;
	logic [7:0]                  sprite_row_s1;

	// Result register.
	logic       out_valid_q;
	logic       collision_q;
	logic [7:0] read_pixels_q;
	logic       display_updated_q;

	logic                              advance;
	logic                              fire;
	logic                              draw_fire;
	logic [sxf_pkg::YSUM_W-1:0]        draw_y;
	logic                              draw_in_screen;
	logic [sxf_pkg::YW-1:0]            row_addr;
	logic [sxf_pkg::SCREEN_WIDTH-1:0]  cur_row;
	logic [7:0]                        sprite_rev;
	logic [sxf_pkg::MASK_W-1:0]        mask_wide;
	logic [sxf_pkg::SCREEN_WIDTH-1:0]  mask;
	logic                              hit;
	logic                              seen_next;
	logic [sxf_pkg::MASK_W-1:0]        read_wide;
	logic [7:0]                        read_rev;
	logic                              res_collision;
	logic [7:0]                        res_pixels;
	logic                              res_updated;

	// The result register moves on when it is empty or its content is taken.
	// The input register then hands its item over, so it can take a new
	// transfer in the same cycle.
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = s1_valid_q && !advance;
	assign fire      = s1_valid_q && advance;
	assign draw_fire = fire && (opcode_s1 == sxf_pkg::OP_DRAW);

	// A draw targets the wrapped origin row plus the row index. Rows below
	// the bottom edge are clipped rather than wrapped.
	assign draw_y         = sxf_pkg::YSUM_W'(y0_s1) + sxf_pkg::YSUM_W'(row_index_s1);
	assign draw_in_screen = draw_y < sxf_pkg::YSUM_W'(sxf_pkg::SCREEN_HEIGHT);

	// Only one row is ever read per item: the draw row for a draw, the
	// origin row otherwise.
	assign row_addr = (opcode_s1 == sxf_pkg::OP_DRAW) ? draw_y[sxf_pkg::YW-1:0] : y0_s1;
	assign cur_row  = rows_q[row_addr];

	// The sprite byte carries its leftmost pixel in bit 7, while the screen
	// row keeps lower columns in lower bits, so the byte is reversed before
	// shifting it to the origin column. Bits shifted past the right edge
	// fall into the extra byte of mask_wide and are dropped.
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			sprite_rev[b] = sprite_row_s1[7-b];
		end
	end

	assign mask_wide = sxf_pkg::MASK_W'(sprite_rev) << x0_s1;
	assign mask      = mask_wide[sxf_pkg::SCREEN_WIDTH-1:0];

	// A collision is a lit pixel that the sprite turns off.
	assign hit       = draw_in_screen && (|(cur_row & mask));
	assign seen_next = ((row_index_s1 == 4'd0) ? 1'b0 : collision_seen_q) | hit;

	// Read: columns past the right edge shift in as zeros.
	assign read_wide = {8'd0, cur_row} >> x0_s1;

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			read_rev[b] = read_wide[7-b];
		end
	end

	always_comb begin
		res_collision = collision_seen_q;
		res_pixels    = 8'd0;
		res_updated   = 1'b0;
		unique case (opcode_s1)
			sxf_pkg::OP_CLEAR: begin
				res_updated = 1'b1;
			end
			sxf_pkg::OP_DRAW: begin
				res_collision = seen_next;
				res_updated   = 1'b1;
			end
			sxf_pkg::OP_READ: begin
				res_pixels = read_rev;
			end
			default: begin
				// The unused code changes nothing and reports the flag only.
				res_updated = 1'b0;
			end
		endcase
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			opcode_s1     <= opcode;
			x0_s1         <= sxf_pkg::X_WRAP[origin_x];
			y0_s1         <= sxf_pkg::Y_WRAP[origin_y];
			row_index_s1  <= row_index;
			sprite_row_s1 <= sprite_row;
		end
	end

	// Framebuffer and collision flag. Clear leaves the flag alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < sxf_pkg::SCREEN_HEIGHT; r++) begin
				rows_q[r] <= '0;
			end
			collision_seen_q <= 1'b0;
		end else if (fire) begin
			if (opcode_s1 == sxf_pkg::OP_CLEAR) begin
				for (int r = 0; r < sxf_pkg::SCREEN_HEIGHT; r++) begin
					rows_q[r] <= '0;
				end
			end else if (draw_fire) begin
				if (draw_in_screen) begin
					rows_q[row_addr] <= cur_row ^ mask;
				end
				collision_seen_q <= seen_next;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			collision_q       <= res_collision;
			read_pixels_q     <= res_pixels;
			display_updated_q <= res_updated;
		end
	end

	assign out_valid       = out_valid_q;
	assign collision       = collision_q;
	assign read_pixels     = read_pixels_q;
	assign display_updated = display_updated_q;

	// With the output side free, the input side must never be held off.
	`SXF_ASSERT(a_no_stall_when_free, !(s1_valid_q && !out_stall) || !in_stall)
	// The collision flag can only be raised by a draw.
	`SXF_ASSERT(a_collision_from_draw, !$rose(collision_seen_q) || $past(draw_fire))
	// A draw at row zero that erases nothing leaves the flag clear.
	`SXF_ASSERT_NEXT(a_row_zero_restart, draw_fire && (row_index_s1 == 4'd0) && !hit,
		!collision_seen_q)
	// Results that update the display never carry read data.
	`SXF_ASSERT(a_update_no_pixels, !(out_valid_q && display_updated_q) || (read_pixels_q == 8'd0))

endmodule

`default_nettype wire
